// ----- sv/pncr_pkg.sv -----
// shared types, constants and microcode table for the palette remap block
package pncr_pkg;

   // input item fields
   typedef struct packed {
      logic              kind;
      logic [7:0]        entry_index;
      logic signed [7:0] red;
      logic signed [7:0] green;
      logic signed [7:0] blue;
   } req_payload_type;

   // result item fields
   typedef struct packed {
      logic [7:0]  remap_index;
      logic [10:0] distance;
      logic        found;
   } rsp_payload_type;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // distances at or above this never qualify
   localparam logic [9:0] DIST_LIMIT = 10'd769;

   // bias register value after reset
   localparam logic signed [7:0] BIAS_RESET = -8'sd10;

   // microprogram addresses
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
   localparam logic [STEP_W-1:0] STEP_DECODE = 3'd1;
   localparam logic [STEP_W-1:0] STEP_SETUP  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_SCAN   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_DRAIN  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_REPLY  = 3'd5;
   localparam logic [STEP_W-1:0] STEP_LOAD   = 3'd6;
   localparam logic [STEP_W-1:0] STEP_IDENT  = 3'd7;

   // jump conditions: when true go to target, else fall through
   typedef enum logic [2:0] {
      COND_NEXT       = 3'd0,
      COND_ALWAYS     = 3'd1,
      COND_WAIT_START = 3'd2,
      COND_IS_LOAD    = 3'd3,
      COND_OUTSIDE    = 3'd4,
      COND_MORE       = 3'd5
   } cond_type;

   // one control word per step
   typedef struct packed {
      cond_type          cond;
      logic [STEP_W-1:0] target;
      logic              busy;
      logic              setup;
      logic              scan_read;
      logic              mem_write;
      logic              reply_best;
      logic              reply_ident;
   } ctrl_word_type;

   // microcode rom
   function automatic ctrl_word_type ucode_word(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '0;
      w.busy = 1'b1;
      case (step)
         STEP_IDLE: begin
            w.cond   = COND_WAIT_START;
            w.target = STEP_IDLE;
            w.busy   = 1'b0;
         end
         STEP_DECODE: begin
            w.cond   = COND_IS_LOAD;
            w.target = STEP_LOAD;
         end
         STEP_SETUP: begin
            w.cond   = COND_OUTSIDE;
            w.target = STEP_IDENT;
            w.setup  = 1'b1;
         end
         STEP_SCAN: begin
            w.cond      = COND_MORE;
            w.target    = STEP_SCAN;
            w.scan_read = 1'b1;
         end
         STEP_DRAIN: begin
            w.cond   = COND_NEXT;
            w.target = STEP_IDLE;
         end
         STEP_REPLY: begin
            w.cond       = COND_ALWAYS;
            w.target     = STEP_IDLE;
            w.reply_best = 1'b1;
         end
         STEP_LOAD: begin
            w.cond      = COND_ALWAYS;
            w.target    = STEP_IDLE;
            w.mem_write = 1'b1;
         end
         STEP_IDENT: begin
            w.cond        = COND_ALWAYS;
            w.target      = STEP_IDLE;
            w.reply_ident = 1'b1;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- sv/pncr_ram.sv -----
// generic single-write, single-read ram with registered read data
module pncr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 112
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- sv/palette_nearest_color_remap.sv -----
// top level: palette store and nearest-color search under microcode control
//
//   channel  ports                          direction  transfer
//   request  start, busy, req_data          in         start high, busy low
//   result   rsp_strobe, rsp_data           out        one cycle strobe
//   config   csr_write_en, csr_write_data   in         write enable high
//
// a load runs the decode and load steps; a query inside the search range runs
// setup, a scan reading one palette entry per cycle from the single ram read
// port, then drain and reply; a query outside the range goes from setup to the
// identity reply. the result strobe is registered, in the cycle after busy ends.
// reset clears the sequencer, the strobe and the bias; palette contents stay
// undefined until loaded. the receiver cannot stall, so no output backpressure.
module palette_nearest_color_remap #(
   parameter int SEARCH_ENTRIES = 112
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  pncr_pkg::req_payload_type req_data,
   output logic                     rsp_strobe,
   output pncr_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_write_en,
   input  logic [7:0]               csr_write_data
);

   localparam int AW = (SEARCH_ENTRIES > 1) ? $clog2(SEARCH_ENTRIES) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(SEARCH_ENTRIES - 1);
   localparam logic [8:0] ENTRIES_9 = 9'(SEARCH_ENTRIES);

   // sequencer
   logic [pncr_pkg::STEP_W-1:0] step_ff, step_in;
   pncr_pkg::ctrl_word_type     ctrl;
   logic                        jump;

   // datapath registers
   pncr_pkg::req_payload_type   req_ff;
   logic signed [7:0]           bias_ff;
   logic signed [8:0]           q_red_ff, q_green_ff, q_blue_ff;
   logic [AW-1:0]               addr_ff;
   logic [AW-1:0]               rd_addr_ff;
   logic                        rd_valid_ff;
   logic [9:0]                  min_dist_ff;
   logic [AW-1:0]               min_pos_ff;
   logic                        hit_ff;
   logic                        rsp_valid_ff;
   pncr_pkg::rsp_payload_type   rsp_ff;

   logic                        accept;
   logic                        in_range;
   logic                        last_addr;
   logic [23:0]                 entry;
   logic signed [9:0]           diff_red, diff_green, diff_blue;
   logic [8:0]                  abs_red, abs_green, abs_blue;
   logic [10:0]                 manhattan;
   logic                        better;

   assign ctrl      = pncr_pkg::ucode_word(step_ff);
   assign busy      = ctrl.busy;
   assign accept    = start & ~ctrl.busy;
   assign in_range  = {1'b0, req_ff.entry_index} < ENTRIES_9;
   assign last_addr = addr_ff == LAST_ADDR;

   // jump condition select
   always_comb begin
      case (ctrl.cond)
         pncr_pkg::COND_NEXT:       jump = 1'b0;
         pncr_pkg::COND_ALWAYS:     jump = 1'b1;
         pncr_pkg::COND_WAIT_START: jump = ~start;
         pncr_pkg::COND_IS_LOAD:    jump = req_ff.kind == pncr_pkg::KIND_LOAD;
         pncr_pkg::COND_OUTSIDE:    jump = ~in_range;
         pncr_pkg::COND_MORE:       jump = ~last_addr;
         default:                   jump = 1'b1;
      endcase
      step_in = jump ? ctrl.target : step_ff + pncr_pkg::STEP_W'(1);
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= pncr_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // bias register
   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= pncr_pkg::BIAS_RESET;
      end else if (csr_write_en) begin
         bias_ff <= csr_write_data;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // palette store
   pncr_ram #(
      .WIDTH (24),
      .DEPTH (SEARCH_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ctrl.mem_write & in_range),
      .wr_addr (req_ff.entry_index[AW-1:0]),
      .wr_data ({req_ff.blue, req_ff.green, req_ff.red}),
      .rd_addr (addr_ff),
      .rd_data (entry)
   );

   // biased query and scan address
   always_ff @(posedge clock) begin
      if (ctrl.setup) begin
         q_red_ff   <= {req_ff.red[7], req_ff.red} + {bias_ff[7], bias_ff};
         q_green_ff <= {req_ff.green[7], req_ff.green} + {bias_ff[7], bias_ff};
         q_blue_ff  <= {req_ff.blue[7], req_ff.blue} + {bias_ff[7], bias_ff};
         addr_ff    <= '0;
      end else if (ctrl.scan_read) begin
         addr_ff <= addr_ff + AW'(1);
      end
   end

   // read tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= ctrl.scan_read;
      end
      rd_addr_ff <= addr_ff;
   end

   // manhattan distance of the entry just read
   always_comb begin
      diff_red   = {q_red_ff[8], q_red_ff} - {{2{entry[7]}}, entry[7:0]};
      diff_green = {q_green_ff[8], q_green_ff} - {{2{entry[15]}}, entry[15:8]};
      diff_blue  = {q_blue_ff[8], q_blue_ff} - {{2{entry[23]}}, entry[23:16]};
      abs_red    = diff_red[9] ? 9'(-diff_red) : diff_red[8:0];
      abs_green  = diff_green[9] ? 9'(-diff_green) : diff_green[8:0];
      abs_blue   = diff_blue[9] ? 9'(-diff_blue) : diff_blue[8:0];
      manhattan  = 11'(abs_red) + 11'(abs_green) + 11'(abs_blue);
      better     = manhattan < {1'b0, min_dist_ff};
   end

   // best match so far, strict compare keeps the lowest index on ties
   always_ff @(posedge clock) begin
      if (ctrl.setup) begin
         min_dist_ff <= pncr_pkg::DIST_LIMIT;
         min_pos_ff  <= '0;
         hit_ff      <= 1'b0;
      end else if (rd_valid_ff && better) begin
         min_dist_ff <= manhattan[9:0];
         min_pos_ff  <= rd_addr_ff;
         hit_ff      <= 1'b1;
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.reply_best | ctrl.reply_ident;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (ctrl.reply_ident) begin
         rsp_ff.remap_index <= req_ff.entry_index;
         rsp_ff.distance    <= '0;
         rsp_ff.found       <= 1'b1;
      end else if (ctrl.reply_best) begin
         rsp_ff.remap_index <= hit_ff ? 8'(min_pos_ff) : 8'd0;
         rsp_ff.distance    <= hit_ff ? {1'b0, min_dist_ff} : 11'd0;
         rsp_ff.found       <= hit_ff;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // a result only ever leaves once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> step_ff == pncr_pkg::STEP_IDLE)
      else $error("result strobe outside idle step");

   // read data is only compared during the scan or the drain step
   a_read_window: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (step_ff == pncr_pkg::STEP_SCAN || step_ff == pncr_pkg::STEP_DRAIN))
      else $error("palette read outside scan window");

   // a miss reports index and distance as zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff.remap_index == 8'd0 &&
      rsp_ff.distance == 11'd0))
      else $error("miss result carries nonzero fields");

   // any reported distance qualifies
   a_dist_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.distance < {1'b0, pncr_pkg::DIST_LIMIT})
      else $error("reported distance above limit");

   // an accepted item keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after accept");

endmodule

// ----- verif/tb_palette_nearest_color_remap.sv -----
// testbench for the palette nearest-color remap block: directed and random loads and searches
module tb_palette_nearest_color_remap;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SEARCH_ENTRIES = 112;
   localparam int SETTLE_CYCLES  = SEARCH_ENTRIES + 10;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int RANDOM_ITEMS   = 620;
   localparam int RANDOM_PHASES  = 8;
   localparam int POOL_SIZE      = 8;
   localparam int MAX_REPORTS    = 10;

   // one queued operation: either a bias register write or an input item
   typedef struct packed {
      logic                      is_bias_write;
      logic [7:0]                bias;
      pncr_pkg::req_payload_type item;
   } pending_op_type;

   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      start          = 1'b0;
   logic                      busy;
   pncr_pkg::req_payload_type req_data       = '0;
   logic                      rsp_strobe;
   pncr_pkg::rsp_payload_type rsp_data;
   logic                      csr_write_en   = 1'b0;
   logic [7:0]                csr_write_data = '0;

   // shadow of the palette and bias register as the block should hold them
   logic signed [7:0] shadow_red   [SEARCH_ENTRIES];
   logic signed [7:0] shadow_green [SEARCH_ENTRIES];
   logic signed [7:0] shadow_blue  [SEARCH_ENTRIES];
   logic signed [7:0] shadow_bias  = pncr_pkg::BIAS_RESET;

   pending_op_type            pending_ops[$];
   pncr_pkg::rsp_payload_type expected_remaps[$];

   int burst_left   = 1;
   int gap_left     = 0;
   int quiet_cycles = 0;
   int cycle_count  = 0;

   int load_count     = 0;
   int ignored_count  = 0;
   int search_count   = 0;
   int identity_count = 0;
   int miss_count     = 0;
   int bias_writes    = 0;
   int result_count   = 0;
   int mismatch_count = 0;

   palette_nearest_color_remap #(
      .SEARCH_ENTRIES(SEARCH_ENTRIES)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   // clock
   always #1 clock = ~clock;

   function automatic int abs_diff(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   // nearest palette entry by manhattan distance, lowest index on ties
   function automatic pncr_pkg::rsp_payload_type nearest_color(
      input pncr_pkg::req_payload_type it);
      pncr_pkg::rsp_payload_type res;
      int qr, qg, qb, d, min_dist, min_pos;
      res = '0;
      if (it.entry_index >= SEARCH_ENTRIES) begin
         res.remap_index = it.entry_index;
         res.found       = 1'b1;
         return res;
      end
      qr = int'($signed(it.red))   + int'(shadow_bias);
      qg = int'($signed(it.green)) + int'(shadow_bias);
      qb = int'($signed(it.blue))  + int'(shadow_bias);
      min_dist = int'(pncr_pkg::DIST_LIMIT);
      min_pos  = -1;
      for (int i = 0; i < SEARCH_ENTRIES; i++) begin
         d = abs_diff(qr, int'(shadow_red[i])) + abs_diff(qg, int'(shadow_green[i]))
           + abs_diff(qb, int'(shadow_blue[i]));
         if (d < min_dist) begin
            min_dist = d;
            min_pos  = i;
         end
      end
      if (min_pos >= 0) begin
         res.remap_index = min_pos[7:0];
         res.distance    = min_dist[10:0];
         res.found       = 1'b1;
      end
      return res;
   endfunction

   // update the shadow for one accepted item and queue its result
   task automatic accept_item(input pncr_pkg::req_payload_type it);
      pncr_pkg::rsp_payload_type res;
      if (it.kind == pncr_pkg::KIND_LOAD) begin
         if (it.entry_index < SEARCH_ENTRIES) begin
            shadow_red[it.entry_index]   = it.red;
            shadow_green[it.entry_index] = it.green;
            shadow_blue[it.entry_index]  = it.blue;
            load_count++;
         end else begin
            ignored_count++;
         end
      end else begin
         res = nearest_color(it);
         if (it.entry_index >= SEARCH_ENTRIES) identity_count++;
         else search_count++;
         if (!res.found) miss_count++;
         expected_remaps.push_back(res);
      end
   endtask

   task automatic push_item(input logic kind, input int idx, input int r, input int g,
                            input int b);
      pending_op_type op;
      op                  = '0;
      op.item.kind        = kind;
      op.item.entry_index = idx[7:0];
      op.item.red         = r[7:0];
      op.item.green       = g[7:0];
      op.item.blue        = b[7:0];
      pending_ops.push_back(op);
   endtask

   task automatic push_bias(input int b);
      pending_op_type op;
      op               = '0;
      op.is_bias_write = 1'b1;
      op.bias          = b[7:0];
      pending_ops.push_back(op);
   endtask

   // component that lands near a pool color once the bias is added
   function automatic int near_component(input int pool_c, input int bias);
      int v;
      v = pool_c - bias + int'($urandom_range(0, 4)) - 2;
      if (v > 127) v = 127;
      if (v < -128) v = -128;
      return v;
   endfunction

   // driver: bursts of items with random gaps, bias writes only when idle
   always @(posedge clock) begin
      pending_op_type op;
      logic           accepted;
      if (reset) begin
         start        <= 1'b0;
         req_data     <= '0;
         csr_write_en <= 1'b0;
         shadow_bias  = pncr_pkg::BIAS_RESET;
         burst_left   = 1;
         gap_left     = 0;
         quiet_cycles = 0;
      end else begin
         accepted = start && !busy;
         if (accepted) accept_item(req_data);
         if (start && !accepted) begin
            // hold the current item until the block takes it
            csr_write_en <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            start        <= 1'b0;
            csr_write_en <= 1'b0;
         end else if (pending_ops.size() == 0) begin
            start        <= 1'b0;
            csr_write_en <= 1'b0;
         end else if (pending_ops[0].is_bias_write) begin
            start <= 1'b0;
            if (accepted || busy || expected_remaps.size() != 0) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= SETTLE_CYCLES) begin
               op             = pending_ops.pop_front();
               csr_write_en   <= 1'b1;
               csr_write_data <= op.bias;
               shadow_bias    = op.bias;
               bias_writes++;
               quiet_cycles   = 0;
            end else begin
               csr_write_en <= 1'b0;
            end
         end else begin
            op           = pending_ops.pop_front();
            start        <= 1'b1;
            req_data     <= op.item;
            csr_write_en <= 1'b0;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               case ($urandom_range(0, 3))
                  0:       gap_left = 0;
                  1:       gap_left = $urandom_range(1, 4);
                  2:       gap_left = $urandom_range(5, 40);
                  default: gap_left = $urandom_range(41, 100);
               endcase
            end
         end
      end
   end

   // monitor: every strobed result against the oldest expectation
   always @(posedge clock) begin
      pncr_pkg::rsp_payload_type want;
      if (!reset && rsp_strobe) begin
         result_count++;
         if (expected_remaps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: index %0d distance %0d found %0b",
                        rsp_data.remap_index, rsp_data.distance, rsp_data.found);
         end else begin
            want = expected_remaps.pop_front();
            if (rsp_data.remap_index !== want.remap_index ||
                rsp_data.distance !== want.distance || rsp_data.found !== want.found) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected index %0d distance %0d found %0b, got %0d %0d %0b",
                           want.remap_index, want.distance, want.found,
                           rsp_data.remap_index, rsp_data.distance, rsp_data.found);
            end
         end
      end
   end

   // watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
   end

   // stimulus, reset and end of run
   initial begin : stimulus
      int pool_red   [POOL_SIZE];
      int pool_green [POOL_SIZE];
      int pool_blue  [POOL_SIZE];
      int phase_bias;
      int counted;
      int target;
      int sel;
      int p;
      int idx;

      for (int i = 0; i < SEARCH_ENTRIES; i++) begin
         shadow_red[i]   = '0;
         shadow_green[i] = '0;
         shadow_blue[i]  = '0;
      end

      // identity remaps and out-of-range loads before the palette is filled
      push_item(pncr_pkg::KIND_QUERY, SEARCH_ENTRIES, 127, -128, 0);
      push_item(pncr_pkg::KIND_QUERY, 255, -128, 127, -1);
      push_item(pncr_pkg::KIND_LOAD, SEARCH_ENTRIES, 1, 2, 3);
      push_item(pncr_pkg::KIND_LOAD, 255, 127, 127, 127);

      // fill every entry with the darkest color, then search under the reset bias
      for (int i = 0; i < SEARCH_ENTRIES; i++)
         push_item(pncr_pkg::KIND_LOAD, i, -128, -128, -128);
      push_item(pncr_pkg::KIND_QUERY, 0, 127, 127, 127);

      // distance limit edge: 771 and 769 miss, 768 hits, equal entries keep lowest index
      push_bias(2);
      push_item(pncr_pkg::KIND_QUERY, 5, 127, 127, 127);
      push_item(pncr_pkg::KIND_LOAD, 60, -128, -128, -126);
      push_item(pncr_pkg::KIND_QUERY, 5, 127, 127, 127);
      push_item(pncr_pkg::KIND_LOAD, 70, -128, -127, -126);
      push_item(pncr_pkg::KIND_QUERY, 6, 127, 127, 127);
      push_item(pncr_pkg::KIND_LOAD, 65, -128, -127, -126);
      push_item(pncr_pkg::KIND_QUERY, 7, 127, 127, 127);

      // largest bias: far query misses, then finds a bright entry
      push_bias(127);
      push_item(pncr_pkg::KIND_QUERY, SEARCH_ENTRIES - 1, 127, 127, 127);
      push_item(pncr_pkg::KIND_LOAD, 30, 127, 127, 127);
      push_item(pncr_pkg::KIND_QUERY, SEARCH_ENTRIES - 1, 127, 127, 127);
      push_item(pncr_pkg::KIND_QUERY, 200, 0, 0, 0);

      // smallest bias
      push_bias(-128);
      push_item(pncr_pkg::KIND_QUERY, 0, -128, -128, -128);
      push_item(pncr_pkg::KIND_QUERY, 1, 127, 127, 127);

      // zero bias: exact matches
      push_bias(0);
      push_item(pncr_pkg::KIND_QUERY, 10, 127, 127, 127);
      push_item(pncr_pkg::KIND_QUERY, 11, -128, -128, -128);

      // small set of colors reused so that ties and exact hits come up
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_red[i]   = int'($urandom_range(0, 255)) - 128;
         pool_green[i] = int'($urandom_range(0, 255)) - 128;
         pool_blue[i]  = int'($urandom_range(0, 255)) - 128;
      end

      // random phases, each under its own bias
      counted = 0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0:       phase_bias = 127;
            1:       phase_bias = -128;
            2:       phase_bias = 0;
            3:       phase_bias = int'($urandom_range(0, 20)) - 10;
            default: phase_bias = int'($urandom_range(0, 255)) - 128;
         endcase
         push_bias(phase_bias);
         target = (phase + 1) * RANDOM_ITEMS / RANDOM_PHASES;
         while (counted < target) begin
            sel = $urandom_range(0, 99);
            p   = $urandom_range(0, POOL_SIZE - 1);
            if (sel < 25) begin
               idx = $urandom_range(0, SEARCH_ENTRIES - 1);
               if ($urandom_range(0, 1))
                  push_item(pncr_pkg::KIND_LOAD, idx, pool_red[p], pool_green[p],
                            pool_blue[p]);
               else
                  push_item(pncr_pkg::KIND_LOAD, idx, $urandom, $urandom, $urandom);
               counted++;
            end else if (sel < 32) begin
               // load outside the store, ignored by the block
               push_item(pncr_pkg::KIND_LOAD, $urandom_range(SEARCH_ENTRIES, 255),
                         $urandom, $urandom, $urandom);
               counted++;
            end else if (sel < 42) begin
               push_item(pncr_pkg::KIND_QUERY, $urandom_range(SEARCH_ENTRIES, 255),
                         $urandom, $urandom, $urandom);
               counted++;
            end else begin
               idx = $urandom_range(0, SEARCH_ENTRIES - 1);
               if ($urandom_range(0, 4) < 2)
                  push_item(pncr_pkg::KIND_QUERY, idx, $urandom, $urandom, $urandom);
               else
                  push_item(pncr_pkg::KIND_QUERY, idx,
                            near_component(pool_red[p], phase_bias),
                            near_component(pool_green[p], phase_bias),
                            near_component(pool_blue[p], phase_bias));
               counted++;
            end
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // drain: all stimulus taken, all results seen, then the block's latency
      while (pending_ops.size() != 0 || start) @(posedge clock);
      while (expected_remaps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d palette loads (%0d out of range ignored), %0d searches, %0d identity",
               load_count, ignored_count, search_count, identity_count);
      $display("%0d bias settings, %0d results checked, %0d without a match, %0d mismatches",
               bias_writes, result_count, miss_count, mismatch_count);
      if (mismatch_count == 0 && expected_remaps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/pncr_pkg.sv
sv/pncr_ram.sv
sv/palette_nearest_color_remap.sv
verif/tb_palette_nearest_color_remap.sv
